@@ rtl/vbe_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Varint byte encoder package
// Shared types and constants for the variable-length byte encoder.
// ----------------------------------------------------------------------------
package vbe_pkg;

  localparam int unsigned ValueW     = 64;
  localparam int unsigned GroupW     = 7;
  // Widest remainder after the first byte: the signed kind keeps 64 - 6 bits.
  localparam int unsigned RestW      = 58;
  localparam int unsigned QueueDepth = 2;

  localparam logic KindUnsigned = 1'b0;
  localparam logic KindSigned   = 1'b1;

  // One classified item: the seven data bits of the first byte and the
  // magnitude bits that still have to go out in 7-bit groups.
  typedef struct packed {
    logic [GroupW-1:0] first;
    logic [RestW-1:0]  rest;
  } entry_t;

  // Queue status as seen by the front and back parts.
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

@@ rtl/varint_byte_encoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Varint byte encoder
// Encodes 64-bit values into variable-length bytes, unsigned or sign-magnitude.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid_i / in_stall_o) carries one value and a kind
// flag per transaction. Kind 0 encodes the value unsigned in 7-bit groups,
// least significant group first. Kind 1 encodes it as sign and magnitude: the
// first byte holds six magnitude bits and the sign in bit 6.
// The output channel (out_valid_o / out_stall_i) carries one encoded byte per
// transaction. Bit 7 of each byte is the continuation flag, and last_o marks
// the final byte of a value. One value gives one to ten bytes.
// From an idle block, a value passes the queue, the back end's item register
// and the output register before its first byte appears. Throughput: the back
// end emits one byte per cycle while the receiver does not stall; a queued
// next value's first byte follows the previous last byte without a gap.
// A two-entry queue between the front end and the back end lets new values be
// taken while earlier ones are still being emitted; in_stall_o rises when it
// is full. When the receiver stalls, the current byte holds in the output
// register and the back end waits. Reset empties the queue and the output.
// ----------------------------------------------------------------------------
module varint_byte_encoder #(
  parameter int unsigned QueueDepth = vbe_pkg::QueueDepth
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       kind_i,
  input  logic [vbe_pkg::ValueW-1:0] value_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [7:0]                 code_byte_o,
  output logic                       last_o
);
  import vbe_pkg::*;

  queue_status_t q_status;
  entry_t        push_entry;
  entry_t        pop_entry;
  logic          push;
  logic          pop;

  // The front end only classifies; it never holds an item itself, so the
  // input stall is exactly the queue being full.
  vbe_front u_front (
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .kind_i       (kind_i),
    .value_i      (value_i),
    .q_status_i   (q_status),
    .push_o       (push),
    .push_entry_o (push_entry)
  );

  vbe_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .pop_i        (pop),
    .pop_entry_o  (pop_entry),
    .status_o     (q_status)
  );

  // The back end shifts out the remaining magnitude seven bits at a time.
  vbe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_status_i  (q_status),
    .pop_entry_i (pop_entry),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .code_byte_o (code_byte_o),
    .last_o      (last_o)
  );

endmodule

@@ rtl/vbe_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Varint encoder front end
// Accepts input transactions and splits each value into first-byte data bits
// and the remaining magnitude.
// ----------------------------------------------------------------------------
module vbe_front (
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         kind_i,
  input  logic [vbe_pkg::ValueW-1:0]   value_i,
  input  vbe_pkg::queue_status_t       q_status_i,
  output logic                         push_o,
  output vbe_pkg::entry_t              push_entry_o
);
  import vbe_pkg::*;

  logic              negative;
  logic [ValueW-1:0] magnitude;

  // The magnitude is read as an unsigned 64-bit value, so the most negative
  // input becomes 2^63 without overflow.
  assign negative  = (kind_i == KindSigned) && value_i[ValueW-1];
  assign magnitude = negative ? (~value_i + {{(ValueW-1){1'b0}}, 1'b1}) : value_i;

  always_comb begin
    if (kind_i == KindSigned) begin
      push_entry_o.first = {negative, magnitude[5:0]};
      push_entry_o.rest  = magnitude[ValueW-1:6];
    end else begin
      push_entry_o.first = value_i[GroupW-1:0];
      push_entry_o.rest  = {1'b0, value_i[ValueW-1:GroupW]};
    end
  end

  assign in_stall_o = q_status_i.full;
  assign push_o     = in_valid_i && !q_status_i.full;

endmodule

@@ rtl/vbe_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Varint encoder item queue
// Short first-in first-out queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module vbe_queue #(
  parameter int unsigned Depth = vbe_pkg::QueueDepth
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  vbe_pkg::entry_t        push_entry_i,
  input  logic                   pop_i,
  output vbe_pkg::entry_t        pop_entry_o,
  output vbe_pkg::queue_status_t status_o
);
  import vbe_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  entry_t          mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push;
  logic            do_pop;

  assign status_o.full  = (count_q == FullCnt);
  assign status_o.empty = (count_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign pop_entry_o    = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

@@ rtl/vbe_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Varint encoder back end
// Takes classified queue items and emits one byte per cycle unless stalled.
// ----------------------------------------------------------------------------
module vbe_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  vbe_pkg::queue_status_t q_status_i,
  input  vbe_pkg::entry_t        pop_entry_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [7:0]             code_byte_o,
  output logic                   last_o
);
  import vbe_pkg::*;

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StFirst  = 2'd1;
  localparam logic [1:0] StGroups = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [GroupW-1:0] first_q, first_d;
  logic [RestW-1:0]  rest_q, rest_d;
  logic              out_valid_q, out_valid_d;
  logic [7:0]        byte_q, byte_d;
  logic              last_q, last_d;

  logic              slot_free;
  logic [RestW-1:0]  next_rest;
  logic              emit;
  logic              emit_last;
  logic              load;

  assign slot_free = !out_valid_q || !out_stall_i;
  assign next_rest = rest_q >> GroupW;

  always_comb begin
    state_d     = state_q;
    first_d     = first_q;
    rest_d      = rest_q;
    byte_d      = byte_q;
    last_d      = last_q;
    emit        = 1'b0;
    emit_last   = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;

    unique case (state_q)
      StIdle: begin
        emit = 1'b0;
      end
      StFirst: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_last = (rest_q == '0);
          byte_d    = {!emit_last, first_q};
          state_d   = emit_last ? StIdle : StGroups;
        end
      end
      StGroups: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_last = (next_rest == '0);
          byte_d    = {!emit_last, rest_q[GroupW-1:0]};
          rest_d    = next_rest;
          state_d   = emit_last ? StIdle : StGroups;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    if (emit) begin
      last_d      = emit_last;
      out_valid_d = 1'b1;
    end

    load = !q_status_i.empty && ((state_q == StIdle) || emit_last);
    if (load) begin
      first_d = pop_entry_i.first;
      rest_d  = pop_entry_i.rest;
      state_d = StFirst;
    end
  end

  assign pop_o       = load;
  assign out_valid_o = out_valid_q;
  assign code_byte_o = byte_q;
  assign last_o      = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    first_q <= first_d;
    rest_q  <= rest_d;
    byte_q  <= byte_d;
    last_q  <= last_d;
  end

endmodule

@@ rtl/vbe_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Varint encoder checker
// Port-level assertions for the varint byte encoder, bound to the top level.
// ----------------------------------------------------------------------------
module vbe_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] code_byte_o,
  input logic       last_o
);

  // A stalled output transaction holds its byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(code_byte_o) && $stable(last_o))
    else $error("output byte changed while stalled");

  // Every byte but the last carries the continuation flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> code_byte_o[7])
    else $error("continuation flag missing on a non-final byte");

  // The final byte never carries the continuation flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> !code_byte_o[7])
    else $error("continuation flag set on the final byte");

endmodule

bind varint_byte_encoder vbe_checker u_vbe_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .code_byte_o (code_byte_o),
  .last_o      (last_o)
);

@@ sim/tb_varint_byte_encoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Varint byte encoder testbench
// Sends values of both kinds into the encoder. A behavioral encoder predicts
// the byte stream for each accepted value, and every byte that comes out is
// checked against it in order. Directed corner values run first, then random
// values under three patterns of source idling and sink stalls.
// ----------------------------------------------------------------------------
module tb_varint_byte_encoder;

  // Clock, reset and the ports of the block.
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        kind_i = vbe_pkg::KindUnsigned;
  logic [vbe_pkg::ValueW-1:0] value_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  code_byte_o;
  logic        last_o;

  // One byte of an encoding as it should appear on the output channel.
  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } enc_byte_t;

  localparam int unsigned StallLimit = 2000;  // cycles with no transaction
  localparam int unsigned DrainCycles = 20;   // watch for stray bytes after draining

  // Bytes predicted for accepted values, oldest first.
  enc_byte_t   pending_bytes[$];
  int unsigned mismatch_count = 0;
  int unsigned idle_cycles = 0;

  // Idle percentages for the source (valid low) and the sink (stall high).
  int unsigned source_idle_pct = 0;
  int unsigned sink_stall_pct = 0;

  varint_byte_encoder i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .kind_i      (kind_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .code_byte_o (code_byte_o),
    .last_o      (last_o)
  );

  always #5 clk_i = ~clk_i;

  // Adds one expected byte at the tail of the prediction queue.
  function automatic void expect_byte(input logic [7:0] code, input logic last);
    enc_byte_t entry;
    entry.code = code;
    entry.last = last;
    pending_bytes.insert(pending_bytes.size(), entry);
  endfunction

  // Appends the bytes that one value encodes to. The unsigned kind takes seven
  // data bits per byte from the start. The signed kind first turns the value
  // into sign and magnitude; the magnitude is kept as a plain 64-bit number,
  // so the most negative value becomes 2^63 and needs all ten bytes.
  function automatic void predict_encoding(input logic kind, input logic [63:0] value);
    logic [63:0] rest;
    logic [7:0]  code;
    if (kind == vbe_pkg::KindUnsigned) begin
      code = {1'b0, value[6:0]};
      rest = value >> 7;
    end else begin
      rest = value[63] ? -value : value;
      code = {1'b0, value[63], rest[5:0]};
      rest = rest >> 6;
    end
    // Continuation flag is set whenever magnitude bits remain.
    code[7] = (rest != '0);
    expect_byte(code, (rest == '0));
    while (rest != '0) begin
      code = {1'b0, rest[6:0]};
      rest = rest >> 7;
      code[7] = (rest != '0);
      expect_byte(code, (rest == '0));
    end
  endfunction

  // Random value with a spread of encoded lengths: full-width patterns, short
  // magnitudes of either sign, and values at or next to a power of two.
  function automatic logic [63:0] random_value();
    logic [63:0] raw;
    int unsigned width;
    raw = {$urandom, $urandom};
    width = $urandom_range(64, 1);
    case ($urandom_range(3))
      0:       return raw;
      1:       return raw >> (64 - width);
      2:       return -(raw >> (64 - width));
      default: return (64'd1 << (width - 1)) - 64'd1 + 64'($urandom_range(2));
    endcase
  endfunction

  // Offers one value and returns once the block has taken it. Valid stays high
  // on return, so back-to-back values keep the channel busy without a gap.
  task automatic send_value(input logic kind, input logic [63:0] value);
    while ($urandom_range(99) < source_idle_pct) begin
      // While idle the payload is junk; the block must ignore it.
      in_valid_i <= 1'b0;
      kind_i     <= 1'($urandom_range(1));
      value_i    <= {$urandom, $urandom};
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= kind;
    value_i    <= value;
    do
      @(posedge clk_i);
    while (in_stall_o);
    predict_encoding(kind, value);
  endtask

  task automatic send_random_values(input int unsigned count);
    logic kind;
    for (int unsigned n = 0; n < count; n++) begin
      kind = 1'($urandom_range(1));
      send_value(kind, random_value());
    end
  endtask

  // Corner values: zero of both kinds, the edges of the lowest byte boundaries,
  // the largest values of each kind and the most negative signed value.
  task automatic test_directed_corners();
    source_idle_pct = 22;
    sink_stall_pct  = 59;
    send_value(vbe_pkg::KindUnsigned, 64'd0);
    send_value(vbe_pkg::KindUnsigned, 64'd1);
    send_value(vbe_pkg::KindUnsigned, 64'd127);
    send_value(vbe_pkg::KindUnsigned, 64'd128);
    send_value(vbe_pkg::KindUnsigned, 64'd16383);
    send_value(vbe_pkg::KindUnsigned, 64'd16384);
    send_value(vbe_pkg::KindUnsigned, 64'h7FFF_FFFF_FFFF_FFFF);
    send_value(vbe_pkg::KindUnsigned, 64'h8000_0000_0000_0000);
    send_value(vbe_pkg::KindUnsigned, 64'hFFFF_FFFF_FFFF_FFFF);
    send_value(vbe_pkg::KindUnsigned, 64'hAAAA_AAAA_AAAA_AAAA);
    send_value(vbe_pkg::KindUnsigned, 64'h5555_5555_5555_5555);
    send_value(vbe_pkg::KindSigned, 64'd0);
    send_value(vbe_pkg::KindSigned, 64'd1);
    send_value(vbe_pkg::KindSigned, 64'd63);
    send_value(vbe_pkg::KindSigned, 64'd64);
    send_value(vbe_pkg::KindSigned, -64'd1);
    send_value(vbe_pkg::KindSigned, -64'd63);
    send_value(vbe_pkg::KindSigned, -64'd64);
    send_value(vbe_pkg::KindSigned, -64'd65);
    send_value(vbe_pkg::KindSigned, 64'h7FFF_FFFF_FFFF_FFFF);
    send_value(vbe_pkg::KindSigned, 64'h8000_0000_0000_0000);
    send_value(vbe_pkg::KindSigned, 64'h5555_5555_5555_5555);
    send_value(vbe_pkg::KindSigned, 64'hAAAA_AAAA_AAAA_AAAA);
  endtask

  // The sink stalls often, so the internal queue fills and in_stall_o rises.
  task automatic test_random_slow_sink();
    source_idle_pct = 22;
    sink_stall_pct  = 59;
    send_random_values(29);
  endtask

  // The source is mostly idle, so the block often runs dry between values.
  task automatic test_random_slow_source();
    source_idle_pct = 59;
    sink_stall_pct  = 22;
    send_random_values(29);
  endtask

  // No idling on either side: values must follow each other without gaps.
  task automatic test_random_full_rate();
    source_idle_pct = 0;
    sink_stall_pct  = 0;
    send_random_values(29);
  endtask

  // Output side: checks each byte transaction against the oldest prediction,
  // then draws the stall for the next cycle.
  always @(posedge clk_i) begin
    enc_byte_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_bytes.size() == 0) begin
        $error("unexpected byte: code_byte %h last %b", code_byte_o, last_o);
        mismatch_count++;
      end else begin
        want = pending_bytes.pop_front();
        if (code_byte_o !== want.code) begin
          $error("code_byte: expected %h, actual %h", want.code, code_byte_o);
          mismatch_count++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %b, actual %b", want.last, last_o);
          mismatch_count++;
        end
      end
    end
    out_stall_i <= ($urandom_range(99) < sink_stall_pct);
  end

  // Watchdog: ends the run when neither channel moves for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("tb_varint_byte_encoder: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_corners();
    test_random_slow_sink();
    test_random_slow_source();
    test_random_full_rate();
    in_valid_i <= 1'b0;

    // Let every predicted byte come out, then watch for stray extra bytes.
    wait (pending_bytes.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0 && pending_bytes.size() == 0) begin
      $display("tb_varint_byte_encoder: done, clean");
    end else begin
      $display("tb_varint_byte_encoder: done, errors");
    end
    $finish;
  end

endmodule
